@@ hdl/cjc_pkg.sv @@
// Package for the curve jump classifier: sizes, register indexes and the
// sequencer state type. No dependencies.
`default_nettype none
package cjc_pkg;

  localparam int MAX_POINTS = 4096;
  // Point counter must hold MAX_POINTS itself.
  localparam int PCW        = $clog2(MAX_POINTS + 1);
  localparam int IDXW       = 12;
  localparam int SUMW       = 48;
  localparam int CFG_AW     = 3;

  localparam logic [SUMW-1:0] SUM_MAX = {SUMW{1'b1}};

  typedef enum logic [0:0] {
    REG_RATIO = 1'b0,
    REG_JUMP  = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_UPD,
    ST_MUL,
    ST_OUT
  } cjc_state_t;

endpackage
`default_nettype wire

@@ hdl/curve_jump_classifier.sv @@
// Top level of the curve jump classifier: point window, restoring
// divider and adder, end-of-curve test, APB register port. Uses cjc_pkg.
// A point is accepted only while the sequencer is idle. A point that forms no
// slope (fewer than two earlier points, zero control span, or dropped beyond
// the maximum count) is only accepted; a window whose slope saturates then
// updates the sum and peak; any other window first runs the one-bit-per-cycle
// restoring divider that forms the Q16.16 slope, then updates the sum through
// the adder and the peak through a compare. The point marked last then
// registers the products, then does the compare, plus any wait for the output
// register to be emptied. One result word leaves per curve, on its last point.
`default_nettype none
module curve_jump_classifier import cjc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // in_tdata, from bit 0: order_value[31:0], ctrl_sample[31:0]
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [63:0]       in_tdata,
  input  wire logic              in_tlast,
  // out_tdata, from bit 0: jump_size[31:0], steepest_index[11:0], zero fill
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [47:0]            out_tdata,
  // out_tuser, from bit 0: is_first_order, too_few_points, count_overflow
  output logic [2:0]             out_tuser,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  cjc_state_t state_r, state_nxt;

  logic [7:0]       ratio_r;
  logic [31:0]      jump_thr_r;

  logic [31:0]      older_order_r, older_order_nxt;
  logic [31:0]      newer_order_r, newer_order_nxt;
  logic [31:0]      older_ctrl_r, older_ctrl_nxt;
  logic [31:0]      newer_ctrl_r, newer_ctrl_nxt;
  logic [PCW-1:0]   count_r, count_nxt;
  logic [SUMW-1:0]  sum_r, sum_nxt;
  logic [31:0]      peak_r, peak_nxt;
  logic [IDXW-1:0]  peak_idx_r, peak_idx_nxt;
  logic [31:0]      peak_jump_r, peak_jump_nxt;
  logic             ovf_r, ovf_nxt;

  logic [31:0]      dctrl_r, dctrl_nxt;
  logic [31:0]      dord_r, dord_nxt;
  logic [32:0]      rem_r, rem_nxt;
  logic [31:0]      dvd_r, dvd_nxt;
  logic [31:0]      quo_r, quo_nxt;
  logic [4:0]       iter_r, iter_nxt;
  logic [IDXW-1:0]  idx_r, idx_nxt;
  logic             last_r, last_nxt;

  logic [31+PCW:0]  prod_a_r, prod_a_nxt;
  logic [SUMW+7:0]  prod_b_r, prod_b_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [31:0]      out_jump_r, out_jump_nxt;
  logic [IDXW-1:0]  out_idx_r, out_idx_nxt;
  logic [2:0]       out_flags_r, out_flags_nxt;

  logic             in_fire;
  logic [31:0]      in_order, in_ctrl;
  logic [32:0]      diff_c, diff_o, abs_c, abs_o;
  logic [32:0]      rem_sh, rem_sub;
  logic [SUMW:0]    sum_add;
  logic             few;
  logic [PCW-1:0]   n2;
  logic [31:0]      jump_sel;
  logic             cfg_wr;

  assign in_order = in_tdata[31:0];
  assign in_ctrl  = in_tdata[63:32];
  assign in_fire  = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);

  // Window differences, 33 bits wide so the magnitude never wraps.
  assign diff_c = {in_ctrl[31], in_ctrl} - {older_ctrl_r[31], older_ctrl_r};
  assign diff_o = {in_order[31], in_order} - {older_order_r[31], older_order_r};
  assign abs_c  = diff_c[32] ? (33'd0 - diff_c) : diff_c;
  assign abs_o  = diff_o[32] ? (33'd0 - diff_o) : diff_o;

  assign rem_sh  = {rem_r[31:0], dvd_r[31]};
  assign rem_sub = rem_sh - {1'b0, dctrl_r};
  assign sum_add = {1'b0, sum_r} + {{(SUMW-31){1'b0}}, quo_r};

  assign few      = (count_r < PCW'(4));
  assign n2       = count_r - PCW'(2);
  assign jump_sel = (peak_r != 32'd0) ? peak_jump_r : 32'd0;

  always_comb begin
    state_nxt       = state_r;
    older_order_nxt = older_order_r;
    newer_order_nxt = newer_order_r;
    older_ctrl_nxt  = older_ctrl_r;
    newer_ctrl_nxt  = newer_ctrl_r;
    count_nxt       = count_r;
    sum_nxt         = sum_r;
    peak_nxt        = peak_r;
    peak_idx_nxt    = peak_idx_r;
    peak_jump_nxt   = peak_jump_r;
    ovf_nxt         = ovf_r;
    dctrl_nxt       = dctrl_r;
    dord_nxt        = dord_r;
    rem_nxt         = rem_r;
    dvd_nxt         = dvd_r;
    quo_nxt         = quo_r;
    iter_nxt        = iter_r;
    idx_nxt         = idx_r;
    last_nxt        = last_r;
    prod_a_nxt      = prod_a_r;
    prod_b_nxt      = prod_b_r;
    out_valid_nxt   = out_valid_r;
    out_jump_nxt    = out_jump_r;
    out_idx_nxt     = out_idx_r;
    out_flags_nxt   = out_flags_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          last_nxt = in_tlast;
          if (count_r >= PCW'(MAX_POINTS)) begin
            ovf_nxt = 1'b1;
            if (in_tlast) begin
              state_nxt = ST_MUL;
            end
          end else begin
            older_order_nxt = newer_order_r;
            older_ctrl_nxt  = newer_ctrl_r;
            newer_order_nxt = in_order;
            newer_ctrl_nxt  = in_ctrl;
            count_nxt       = count_r + PCW'(1);
            dctrl_nxt       = abs_c[31:0];
            dord_nxt        = abs_o[31:0];
            idx_nxt         = IDXW'(count_r - PCW'(1));
            rem_nxt         = {17'd0, abs_o[31:16]};
            dvd_nxt         = {abs_o[15:0], 16'd0};
            iter_nxt        = 5'd0;
            if (count_r >= PCW'(2) && abs_c[31:0] != 32'd0) begin
              // The quotient reaches 2^32 exactly when the upper half of the
              // order step is not below the control span.
              if ({16'd0, abs_o[31:16]} >= abs_c[31:0]) begin
                quo_nxt   = 32'hFFFF_FFFF;
                state_nxt = ST_UPD;
              end else begin
                state_nxt = ST_DIV;
              end
            end else if (in_tlast) begin
              state_nxt = ST_MUL;
            end
          end
        end
      end
      ST_DIV: begin
        if (!rem_sub[32]) begin
          rem_nxt = rem_sub;
          quo_nxt = {quo_r[30:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          quo_nxt = {quo_r[30:0], 1'b0};
        end
        dvd_nxt  = {dvd_r[30:0], 1'b0};
        iter_nxt = iter_r + 5'd1;
        if (iter_r == 5'd31) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        sum_nxt = sum_add[SUMW] ? SUM_MAX : sum_add[SUMW-1:0];
        if (quo_r > peak_r) begin
          peak_nxt      = quo_r;
          peak_idx_nxt  = idx_r;
          peak_jump_nxt = dord_r;
        end
        state_nxt = last_r ? ST_MUL : ST_IDLE;
      end
      ST_MUL: begin
        prod_a_nxt = {{PCW{1'b0}}, peak_r} * {{32{1'b0}}, n2};
        prod_b_nxt = {{SUMW{1'b0}}, ratio_r} * {8'd0, sum_r};
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_jump_nxt  = few ? 32'd0 : jump_sel;
          out_idx_nxt   = (few || peak_r == 32'd0) ? '0 : peak_idx_r;
          out_flags_nxt[0] = !few && ({{(SUMW-24-PCW){1'b0}}, prod_a_r} > prod_b_r)
                             && (jump_sel > jump_thr_r);
          out_flags_nxt[1] = few;
          out_flags_nxt[2] = ovf_r;
          // The curve ends here; clear the window, count, sum, peak and overflow flag.
          older_order_nxt = '0;
          newer_order_nxt = '0;
          older_ctrl_nxt  = '0;
          newer_ctrl_nxt  = '0;
          count_nxt       = '0;
          sum_nxt         = '0;
          peak_nxt        = '0;
          peak_idx_nxt    = '0;
          peak_jump_nxt   = '0;
          ovf_nxt         = 1'b0;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      older_order_r <= '0;
      newer_order_r <= '0;
      older_ctrl_r  <= '0;
      newer_ctrl_r  <= '0;
      count_r       <= '0;
      sum_r         <= '0;
      peak_r        <= '0;
      peak_idx_r    <= '0;
      peak_jump_r   <= '0;
      ovf_r         <= 1'b0;
      out_valid_r   <= 1'b0;
      last_r        <= 1'b0;
      iter_r        <= '0;
    end else begin
      state_r       <= state_nxt;
      older_order_r <= older_order_nxt;
      newer_order_r <= newer_order_nxt;
      older_ctrl_r  <= older_ctrl_nxt;
      newer_ctrl_r  <= newer_ctrl_nxt;
      count_r       <= count_nxt;
      sum_r         <= sum_nxt;
      peak_r        <= peak_nxt;
      peak_idx_r    <= peak_idx_nxt;
      peak_jump_r   <= peak_jump_nxt;
      ovf_r         <= ovf_nxt;
      out_valid_r   <= out_valid_nxt;
      last_r        <= last_nxt;
      iter_r        <= iter_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dctrl_r     <= dctrl_nxt;
    dord_r      <= dord_nxt;
    rem_r       <= rem_nxt;
    dvd_r       <= dvd_nxt;
    quo_r       <= quo_nxt;
    idx_r       <= idx_nxt;
    prod_a_r    <= prod_a_nxt;
    prod_b_r    <= prod_b_nxt;
    out_jump_r  <= out_jump_nxt;
    out_idx_r   <= out_idx_nxt;
    out_flags_r <= out_flags_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_idx_r, out_jump_r};
  assign out_tuser  = out_flags_r;

  // Register port: the index is the word address, so paddr[2] picks it.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r    <= 8'd10;
      jump_thr_r <= 32'd0;
    end else if (cfg_wr) begin
      case (cfg_reg_t'(cfg_paddr[2]))
        REG_RATIO: ratio_r    <= cfg_pwdata[7:0];
        REG_JUMP:  jump_thr_r <= cfg_pwdata;
        default:   ratio_r    <= ratio_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg_t'(cfg_paddr[2]))
      REG_RATIO: cfg_prdata = {24'd0, ratio_r};
      REG_JUMP:  cfg_prdata = jump_thr_r;
      default:   cfg_prdata = 32'd0;
    endcase
  end

`ifndef SYNTHESIS
  // The divider remainder stays below the control span on every step.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < {1'b0, dctrl_r}))
    else $error("divider remainder not below divisor");

  // The point counter never runs past the maximum curve length.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= PCW'(MAX_POINTS))
    else $error("point counter beyond maximum");

  // A short curve reports neither a jump nor a steepest point.
  a_few_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> (out_tdata == 48'd0 && !out_tuser[0]))
    else $error("short curve word carries jump data");
`endif

endmodule
`default_nettype wire
